// File: rtl/eit_pkg.sv
// ----------------------------------------------------------------------------
// eit_pkg
// Types and constants shared by the encounter id tracker.
// ----------------------------------------------------------------------------
package eit_pkg;

	localparam logic [1:0] REG_INITIAL_TIME    = 2'd0;
	localparam logic [1:0] REG_SERVICE_ID      = 2'd1;
	localparam logic [1:0] REG_LOG_MIN_WAIT    = 2'd2;
	localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd3;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [31:0] LOG_MIN_WAIT_RESET = 32'd15;

	typedef struct packed {
		logic [63:0] eph_low;
		logic [55:0] eph_high;
		logic [31:0] beacon;
		logic [63:0] location;
		logic [31:0] beacon_start;
		logic [7:0]  beacon_span;
		logic [31:0] local_start;
		logic [7:0]  local_span;
		logic [7:0]  strength;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_TICK
	} state_t;

endpackage

// File: rtl/eit_slot_mem.sv
// ----------------------------------------------------------------------------
// eit_slot_mem
// Slot table: one write port, one registered read port, per-slot valid bits.
// ----------------------------------------------------------------------------
module eit_slot_mem
	import eit_pkg::*;
#(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output slot_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  slot_t         wr_data,
	input  logic          clr_en
);

	slot_t          mem [SLOTS];
	slot_t          data_q;
	logic [SLOTS-1:0] valid_q;
	logic           rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
	end

	// cleared or never-written slots read as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr] && !(clr_en && wr_addr == rd_addr);
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (clr_en) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_valid_q ? data_q : '0;

endmodule

// File: rtl/encounter_id_tracker.sv
// ----------------------------------------------------------------------------
// encounter_id_tracker
// Beacon sighting table with round-robin replacement and timed emission.
// ----------------------------------------------------------------------------
// Scan: a rejected beat leaves the tracker idle; an accepted one reads slots one per cycle,
// stops at the first id match (or after the last slot) and writes back.
// Tick: one slot a cycle; due slots are emitted by strobe
// (receiver cannot stall), the final record of the tick flagged by last.
// Reset clears control registers and slot valid bits at once; no clearing pass.
module encounter_id_tracker
	import eit_pkg::*;
#(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned EPH_ID_BYTES = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   action,
	input  logic [7:0]             packet_length,
	input  logic [31:0]            bcn_id,
	input  logic [63:0]            loc_id,
	input  logic [31:0]            beacon_time,
	input  logic [63:0]            eph_id_low,
	input  logic [55:0]            eph_id_high,
	input  logic signed [7:0]      rssi,
	output logic                   strobe,
	output logic [63:0]            out_eph_low,
	output logic [55:0]            out_eph_high,
	output logic [31:0]            out_beacon_id,
	output logic [63:0]            out_location,
	output logic [31:0]            out_beacon_start,
	output logic [7:0]             out_beacon_span,
	output logic [31:0]            out_dongle_start,
	output logic [7:0]             out_dongle_span,
	output logic signed [7:0]      out_rssi,
	output logic [3:0]             out_slot,
	output logic                   last
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned LOW_BITS  = (EPH_ID_BYTES >= 8) ? 64 : 8 * EPH_ID_BYTES;
	localparam int unsigned HIGH_BITS = (EPH_ID_BYTES > 8) ? 8 * (EPH_ID_BYTES - 8) : 0;
	localparam logic [63:0] MASK_LO = (LOW_BITS >= 64) ? '1 : ((64'd1 << LOW_BITS) - 64'd1);
	localparam logic [55:0] MASK_HI = (HIGH_BITS >= 56) ? '1 :
		56'(((64'd1 << HIGH_BITS) - 64'd1));
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	state_t state_q, state_d;

	logic [31:0] time_q;
	logic [15:0] service_q;
	logic [31:0] wait_q;
	logic [7:0]  exp_len_q;
	logic [AW-1:0] ptr_q;

	// captured item
	logic [31:0] bid_q, btime_q;
	logic [63:0] loc_q, elo_q;
	logic [55:0] ehi_q;
	logic [7:0]  rssi_q;

	// sweep: rd_q addresses the read issued; cmp_q is the slot whose data is out
	logic [AW-1:0] rd_q, cmp_q;
	logic          cmp_v_q;
	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	slot_t         hit_data_q;

	slot_t         rd_data, wr_data;
	logic          wr_en, clr_en;
	logic [AW-1:0] wr_addr, rd_addr;

	// pending emission, held back one beat to know which record is last
	logic          pend_q;
	slot_t         pend_data_q;
	logic [AW-1:0] pend_slot_q;

	// the last slot being due while another is pending needs an extra strobe after the sweep
	logic          tail_q;

	logic match, due;
	logic [31:0] age;

	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign busy      = (state_q != ST_IDLE);

	assign match = (rd_data.eph_low == elo_q) && (rd_data.eph_high == ehi_q);
	assign age   = time_q - rd_data.local_start;
	assign due   = (rd_data.local_start != 32'd0) && (age > wait_q);

	eit_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clr_en  (clr_en)
	);

	// slot 0 is read on the accepting edge
	assign rd_addr = (state_q == ST_IDLE) ? '0 : rd_q;

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		clr_en  = 1'b0;
		wr_addr = cmp_q;
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action) begin
						state_d = ST_TICK;
					end else if (packet_length == exp_len_q &&
						bcn_id[31:16] == service_q) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (cmp_v_q && match) begin
					state_d = ST_WRITE;
				end else if (cmp_v_q && cmp_q == LAST_SLOT) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				wr_en = 1'b1;
				if (hit_q) begin
					wr_addr = hit_slot_q;
					wr_data = hit_data_q;
					wr_data.local_span  = 8'(time_q - hit_data_q.local_start);
					wr_data.beacon_span = 8'(btime_q - hit_data_q.beacon_start + 32'd1);
				end else begin
					wr_addr = ptr_q;
					wr_data.eph_low      = elo_q;
					wr_data.eph_high     = ehi_q;
					wr_data.beacon       = bid_q;
					wr_data.location     = loc_q;
					wr_data.beacon_start = btime_q;
					wr_data.beacon_span  = 8'd1;
					wr_data.local_start  = time_q;
					wr_data.local_span   = 8'd0;
					wr_data.strength     = rssi_q;
				end
				state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (cmp_v_q && due) begin
					clr_en = 1'b1;
				end
				if (cmp_v_q && cmp_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			time_q    <= '0;
			service_q <= '0;
			wait_q    <= LOG_MIN_WAIT_RESET;
			exp_len_q <= '0;
			ptr_q     <= '0;
			rd_q      <= '0;
			cmp_q     <= '0;
			cmp_v_q   <= 1'b0;
			hit_q     <= 1'b0;
			pend_q    <= 1'b0;
			strobe    <= 1'b0;
			last      <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= 1'b0;
			last    <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					8'(REG_INITIAL_TIME):    time_q    <= cfg_data;
					8'(REG_SERVICE_ID):      service_q <= cfg_data[15:0];
					8'(REG_LOG_MIN_WAIT):    wait_q    <= cfg_data;
					8'(REG_EXPECTED_LENGTH): exp_len_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE) begin
				rd_q    <= '0;
				cmp_v_q <= 1'b0;
				hit_q   <= 1'b0;
				pend_q  <= 1'b0;
				if (tail_q) begin
					strobe <= 1'b1;
					last   <= 1'b1;
				end
				if (start && action) begin
					time_q <= time_q + 32'd1;
					rd_q   <= AW'(1);
					cmp_q  <= '0;
					cmp_v_q <= 1'b1;
				end else if (state_d == ST_SCAN) begin
					rd_q   <= AW'(1);
					cmp_q  <= '0;
					cmp_v_q <= 1'b1;
				end
			end else if (state_q == ST_SCAN || state_q == ST_TICK) begin
				cmp_q <= rd_q;
				rd_q  <= (rd_q == LAST_SLOT) ? '0 : rd_q + AW'(1);
				if (cmp_v_q && cmp_q == LAST_SLOT) begin
					cmp_v_q <= 1'b0;
				end
				if (state_q == ST_SCAN && cmp_v_q && match) begin
					hit_q      <= 1'b1;
					hit_slot_q <= cmp_q;
					hit_data_q <= rd_data;
				end
				if (state_q == ST_TICK && cmp_v_q) begin
					if (due) begin
						if (pend_q) begin
							strobe <= 1'b1;
						end
						pend_q      <= 1'b1;
						pend_data_q <= rd_data;
						pend_slot_q <= cmp_q;
					end
					if (cmp_q == LAST_SLOT && (due || pend_q)) begin
						strobe <= 1'b1;
						last   <= !(due && pend_q);
					end
				end
			end else if (state_q == ST_WRITE) begin
				if (!hit_q) begin
					ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else begin
			tail_q <= (state_q == ST_TICK) && cmp_v_q && (cmp_q == LAST_SLOT) &&
				due && pend_q;
		end
	end

	// output record: the pending due slot, or the last slot itself when it is due with none pending
	slot_t out_q;
	logic [AW-1:0] out_slot_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_TICK && cmp_v_q) begin
			if (cmp_q == LAST_SLOT && due && !pend_q) begin
				out_q      <= rd_data;
				out_slot_q <= cmp_q;
			end else if (cmp_q == LAST_SLOT && due && pend_q) begin
				// two records pending at the end: emit older now, newest next
				out_q      <= pend_data_q;
				out_slot_q <= pend_slot_q;
			end else begin
				out_q      <= pend_data_q;
				out_slot_q <= pend_slot_q;
			end
		end
		if (state_q == ST_IDLE && tail_q) begin
			out_q      <= pend_data_q;
			out_slot_q <= pend_slot_q;
		end
		if (start && state_q == ST_IDLE) begin
			bid_q   <= bcn_id;
			loc_q   <= loc_id;
			btime_q <= beacon_time;
			elo_q   <= eph_id_low & MASK_LO;
			ehi_q   <= eph_id_high & MASK_HI;
			rssi_q  <= rssi;
		end
	end

	assign out_eph_low      = out_q.eph_low;
	assign out_eph_high     = out_q.eph_high;
	assign out_beacon_id    = out_q.beacon;
	assign out_location     = out_q.location;
	assign out_beacon_start = out_q.beacon_start;
	assign out_beacon_span  = out_q.beacon_span;
	assign out_dongle_start = out_q.local_start;
	assign out_dongle_span  = out_q.local_span;
	assign out_rssi         = out_q.strength;
	assign out_slot         = 4'(out_slot_q);

endmodule

// File: test/encounter_id_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encounter_id_tracker_tb
// Drives scan and tick commands into the sighting table under several register
// settings and checks every emitted record against a local table predictor.
// ----------------------------------------------------------------------------
module encounter_id_tracker_tb;
	import eit_pkg::*;

	localparam int NSLOT = 16;
	localparam int DRAIN = NSLOT + 6;

	typedef struct {
		logic        act;
		logic [7:0]  plen;
		logic [31:0] bid;
		logic [63:0] loc;
		logic [31:0] btime;
		logic [63:0] elo;
		logic [55:0] ehi;
		logic [7:0]  rs;
	} cmd_t;

	typedef struct {
		slot_t      sl;
		logic [3:0] idx;
		logic       lst;
	} record_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic action;
	logic [7:0] packet_length;
	logic [31:0] bcn_id, beacon_time;
	logic [63:0] loc_id, eph_id_low;
	logic [55:0] eph_id_high;
	logic signed [7:0] rssi;
	logic strobe, last;
	logic [63:0] out_eph_low, out_location;
	logic [55:0] out_eph_high;
	logic [31:0] out_beacon_id, out_beacon_start, out_dongle_start;
	logic [7:0] out_beacon_span, out_dongle_span;
	logic signed [7:0] out_rssi;
	logic [3:0] out_slot;

	encounter_id_tracker uut (.*);

	// table model
	slot_t       tbl[NSLOT];
	logic [31:0] now_time, svc_id, min_wait;
	logic [7:0]  want_len;
	logic [3:0]  rr_ptr;
	record_t     pending_records[$];
	int          errors = 0;
	int          burst_left = 0;
	logic [63:0] pool_lo[24];
	logic [55:0] pool_hi[24];

	function automatic void model_item(cmd_t c);
		record_t r;
		int hit;
		hit = 0;
		if (c.act) begin
			now_time = now_time + 1;
			for (int s = 0; s < NSLOT; s++) begin
				if (tbl[s].local_start != 0 && (now_time - tbl[s].local_start) > min_wait) begin
					r.sl = tbl[s];
					r.idx = s[3:0];
					r.lst = 1'b0;
					pending_records.push_back(r);
					tbl[s] = '0;
					hit = 1;
				end
			end
			// flag goes on the final record of this tick only
			if (hit == 1) pending_records[$].lst = 1'b1;
			return;
		end
		if (c.plen != want_len || c.bid[31:16] != svc_id[15:0]) return;
		for (int s = 0; s < NSLOT; s++) begin
			if (tbl[s].eph_low == c.elo && tbl[s].eph_high == c.ehi) begin
				tbl[s].local_span = 8'(now_time - tbl[s].local_start);
				tbl[s].beacon_span = 8'(c.btime - tbl[s].beacon_start + 1);
				return;
			end
		end
		tbl[rr_ptr] = '{c.elo, c.ehi, c.bid, c.loc, c.btime, 8'd1, now_time, 8'd0, c.rs};
		rr_ptr = rr_ptr + 1;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// results cannot be held off: check every strobe beat
	always @(posedge clk) begin
		record_t e;
		if (strobe) begin
			if (pending_records.size() == 0) begin
				$display("%t unexpected record slot %0d", $realtime, out_slot);
				errors++;
			end else begin
				e = pending_records.pop_front();
				if ({out_eph_low, out_eph_high, out_beacon_id, out_location, out_beacon_start,
				     out_beacon_span, out_dongle_start, out_dongle_span, out_rssi} !== e.sl ||
				    out_slot !== e.idx || last !== e.lst) begin
					$display("%t mismatch exp slot %0d %h last %b / act slot %0d %h last %b",
						$realtime, e.idx, e.sl, e.lst, out_slot,
						{out_eph_low, out_eph_high, out_beacon_id, out_location,
						 out_beacon_start, out_beacon_span, out_dongle_start,
						 out_dongle_span, out_rssi}, last);
					errors++;
				end
			end
		end
	end

	task automatic send(cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
		burst_left--;
		start <= 1'b1;
		action <= c.act;
		packet_length <= c.plen;
		bcn_id <= c.bid;
		loc_id <= c.loc;
		beacon_time <= c.btime;
		eph_id_low <= c.elo;
		eph_id_high <= c.ehi;
		rssi <= c.rs;
		do @(posedge clk); while (busy);
		model_item(c);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_records.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INDEX_W'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_INITIAL_TIME: now_time = val;
			REG_SERVICE_ID: svc_id = {16'd0, val[15:0]};
			REG_LOG_MIN_WAIT: min_wait = val;
			REG_EXPECTED_LENGTH: want_len = val[7:0];
			default: ;
		endcase
	endtask

	function automatic cmd_t rand_cmd(bit good);
		cmd_t c;
		int k;
		k = $urandom_range(0, 23);
		c.act = ($urandom_range(0, 3) == 0);
		c.plen = good ? want_len : 8'($urandom);
		c.bid = good ? {svc_id[15:0], 16'($urandom)} : $urandom;
		c.loc = {$urandom, $urandom};
		c.btime = $urandom;
		c.rs = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			c.elo = {$urandom, $urandom};
			c.ehi = {24'($urandom), $urandom};
		end else begin
			c.elo = pool_lo[k];
			c.ehi = pool_hi[k];
		end
		return c;
	endfunction

	cmd_t dir_tbl[$];

	initial begin
		cmd_t c;
		logic [31:0] wait_set[5];
		logic [31:0] time_set[5];
		logic [15:0] svc_set[5];
		logic [7:0]  len_set[5];
		wait_set = '{0, 2, 32'hFFFF_FFFF, 5, 1};
		time_set = '{32'hFFFF_FFF8, 0, 7, 32'h8000_0000, 3};
		svc_set  = '{16'hFFFF, 16'h0000, 16'hA5C3, 16'h0001, 16'h7E00};
		len_set  = '{8'hFF, 8'h00, 8'd31, 8'h80, 8'd1};
		arst_n = 0;
		start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		action = 0; packet_length = 0; bcn_id = 0; loc_id = 0;
		beacon_time = 0; eph_id_low = 0; eph_id_high = 0; rssi = 0;
		now_time = 0; svc_id = 0; min_wait = LOG_MIN_WAIT_RESET; want_len = 0; rr_ptr = 0;
		foreach (tbl[s]) tbl[s] = '0;
		for (int i = 0; i < 24; i++) begin
			pool_lo[i] = {$urandom, $urandom};
			pool_hi[i] = {24'($urandom), $urandom};
		end
		pool_lo[0] = '0; pool_hi[0] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, then enough ticks to pass the reset wait and reach emission
		dir_tbl = '{
			'{1'b1, 8'd0, 32'h0, 64'h0, 32'h0, 64'h0, 56'h0, 8'h00},           // tick, empty
			'{1'b0, 8'd0, 32'h0000_0001, 64'h1, 32'd10, 64'h0, 56'h0, 8'h05}, // zero id, time 1
			'{1'b0, 8'd0, 32'h0, 64'h2, 32'd12, 64'h0, 56'h0, 8'h06},          // hit slot 0
			'{1'b0, 8'd1, 32'h0, 64'h3, 32'd0, 64'h11, 56'h0, 8'h00},          // bad length
			'{1'b0, 8'd0, 32'h0001_0000, 64'h4, 32'd0, 64'h22, 56'h0, 8'h00},  // bad service
			'{1'b0, 8'd0, 32'h0000_FFFF, '1, '1, '1, '1, 8'h7F},
			'{1'b0, 8'd0, 32'h0000_8000, '0, 32'h0, 64'h1, 56'h0, 8'h80},
			'{1'b0, 8'd0, 32'h0000_0000, '1, 32'h5, '1, '1, 8'h01}             // hit, btime wrap
		};
		foreach (dir_tbl[i]) send(dir_tbl[i]);
		for (int i = 0; i < 18; i++) begin
			c = dir_tbl[0];
			send(c);
		end

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_LOG_MIN_WAIT, wait_set[ph]);
			write_reg(REG_SERVICE_ID, {16'($urandom), svc_set[ph]});
			write_reg(REG_EXPECTED_LENGTH, {24'($urandom), len_set[ph]});
			write_reg(REG_INITIAL_TIME, time_set[ph]);
			for (int i = 0; i < 56; i++) send(rand_cmd($urandom_range(0, 9) != 0));
			// flush out whatever is still due
			for (int i = 0; i < 8 && wait_set[ph] < 10; i++) begin
				c = rand_cmd(1);
				c.act = 1'b1;
				send(c);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_records.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending_records.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
